/* src/assert_macros.svh */
// Assertion macros shared by the front, queue and back-end modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed: forbidden condition");

// ante implies cons in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/mcbt_pkg.sv */
// Shared types and constants of the MIDI clock beat tracker.
package mcbt_pkg;

  // MIDI status codes
  localparam logic [7:0] MSG_SPP      = 8'hF2;
  localparam logic [7:0] MSG_REALTIME = 8'hF8;
  localparam logic [7:0] MSG_CLOCK    = 8'hF8;
  localparam logic [7:0] MSG_START    = 8'hFA;
  localparam logic [7:0] MSG_CONTINUE = 8'hFB;
  localparam logic [7:0] MSG_STOP     = 8'hFC;

  localparam int unsigned DATA_SHIFT = 7;
  localparam int unsigned POS_W      = 2 * DATA_SHIFT;
  // position * 6 needs three more bits
  localparam int unsigned PROD_W     = POS_W + 3;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CPB_W      = 7;

  // configuration register indexes
  localparam logic REG_CLOCKS_PER_BEAT = 1'b0;
  localparam logic REG_CYCLE_LENGTH    = 1'b1;

  localparam logic [CPB_W-1:0]   CLOCKS_PER_BEAT_RST = 7'd6;
  localparam logic [COUNT_W-1:0] CYCLE_LENGTH_RST    = 8'd96;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    CMD_CLOCK,
    CMD_START,
    CMD_STOP,
    CMD_CONTINUE,
    CMD_SPP
  } cmd_kind_e;

  // one classified command passed from front to back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

/* src/mcbt_front.sv */
// Front end: classifies received MIDI bytes and assembles SPP positions.
`include "assert_macros.svh"

module mcbt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rx_valid_i,
  input  logic [7:0]      rx_byte_i,
  output logic            rx_ready_o,
  input  logic            full_i,
  output logic            push_o,
  output mcbt_pkg::cmd_t  cmd_o
);

  logic       accept;
  logic       spp_pending_q, spp_pending_d;
  logic       spp_left_q, spp_left_d;
  logic [7:0] spp_low_q, spp_low_d;

  assign rx_ready_o = !full_i;
  assign accept     = rx_valid_i && !full_i;

  // classify byte, update SPP capture
  always_comb begin
    spp_pending_d = spp_pending_q;
    spp_left_d    = spp_left_q;
    spp_low_d     = spp_low_q;
    push_o        = 1'b0;
    cmd_o.kind    = mcbt_pkg::CMD_CLOCK;
    cmd_o.pos     = {rx_byte_i[mcbt_pkg::DATA_SHIFT-1:0],
                     spp_low_q[mcbt_pkg::DATA_SHIFT-1:0]};
    if (accept) begin
      if (rx_byte_i >= mcbt_pkg::MSG_REALTIME) begin
        // realtime: leaves SPP capture untouched
        unique case (rx_byte_i)
          mcbt_pkg::MSG_CLOCK: begin
            push_o     = 1'b1;
            cmd_o.kind = mcbt_pkg::CMD_CLOCK;
          end
          mcbt_pkg::MSG_START: begin
            push_o     = 1'b1;
            cmd_o.kind = mcbt_pkg::CMD_START;
          end
          mcbt_pkg::MSG_STOP: begin
            push_o     = 1'b1;
            cmd_o.kind = mcbt_pkg::CMD_STOP;
          end
          mcbt_pkg::MSG_CONTINUE: begin
            push_o     = 1'b1;
            cmd_o.kind = mcbt_pkg::CMD_CONTINUE;
          end
          default: push_o = 1'b0;
        endcase
      end else if (!rx_byte_i[7]) begin
        // data byte
        if (spp_pending_q) begin
          if (spp_left_q) begin
            spp_low_d  = rx_byte_i;
            spp_left_d = 1'b0;
          end else begin
            push_o        = 1'b1;
            cmd_o.kind    = mcbt_pkg::CMD_SPP;
            spp_pending_d = 1'b0;
          end
        end
      end else begin
        // other status: drops pending capture, SPP starts a new one
        spp_pending_d = (rx_byte_i == mcbt_pkg::MSG_SPP);
        spp_left_d    = (rx_byte_i == mcbt_pkg::MSG_SPP);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_pending_q <= 1'b0;
      spp_left_q    <= 1'b0;
    end else begin
      spp_pending_q <= spp_pending_d;
      spp_left_q    <= spp_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spp_low_q <= spp_low_d;
  end

  `ASSERT_IMPLY(a_left_needs_pending, spp_left_q, spp_pending_q)
  `ASSERT_IMPLY(a_push_accepted, push_o, accept)

endmodule

/* src/mcbt_fifo.sv */
// Command queue between front and back.
`include "assert_macros.svh"

module mcbt_fifo #(
  parameter int unsigned Depth = mcbt_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcbt_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output mcbt_pkg::cmd_t  cmd_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mcbt_pkg::cmd_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FullCnt);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o)
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o)

endmodule

/* src/mcbt_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module mcbt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mcbt_pkg::PROD_W-1:0]   dividend_i,
  input  logic [mcbt_pkg::COUNT_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [mcbt_pkg::COUNT_W-1:0]  quotient_o,
  output logic [mcbt_pkg::COUNT_W-1:0]  remainder_o
);

  localparam int unsigned StepW = $clog2(mcbt_pkg::PROD_W);
  localparam logic [StepW-1:0] LastStep = StepW'(mcbt_pkg::PROD_W - 1);

  logic                           busy_q, done_q;
  logic [StepW-1:0]               step_q;
  logic [mcbt_pkg::PROD_W-1:0]    quo_q;
  logic [mcbt_pkg::COUNT_W-1:0]   rem_q, div_q;
  logic [mcbt_pkg::COUNT_W:0]     trial;
  logic                           fits;

  // shift in next dividend bit, subtract if it fits
  // (a zero divisor leaves the low dividend bits as remainder)
  assign trial = {rem_q, quo_q[mcbt_pkg::PROD_W-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[mcbt_pkg::PROD_W-2:0], fits};
      rem_q <= fits ? mcbt_pkg::COUNT_W'(trial - {1'b0, div_q})
                    : trial[mcbt_pkg::COUNT_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[mcbt_pkg::COUNT_W-1:0];
  assign remainder_o = rem_q;

endmodule

/* src/mcbt_back.sv */
// Back end: clock counter, run state, beat detection and SPP reposition.
`include "assert_macros.svh"

module mcbt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command queue
  input  logic                          empty_i,
  input  mcbt_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  // beat output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcbt_pkg::COUNT_W-1:0]  out_beat_o
);

  mcbt_pkg::back_state_e          state_q, state_d;
  logic [mcbt_pkg::CPB_W-1:0]     cpb_q;
  logic [mcbt_pkg::COUNT_W-1:0]   cycle_len_q;
  logic [mcbt_pkg::COUNT_W-1:0]   count_q, count_d, count_inc;
  logic                           paused_q, paused_d;
  logic                           is_spp_q, is_spp_d;
  logic [mcbt_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic                           out_valid_q, out_valid_d;
  logic [mcbt_pkg::COUNT_W-1:0]   beat_q, beat_d;
  logic                           div_start, div_done;
  logic [mcbt_pkg::PROD_W-1:0]    div_dividend;
  logic [mcbt_pkg::COUNT_W-1:0]   div_divisor, div_quo, div_rem;
  logic                           out_free;

  mcbt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // counter advance with wrap at cycle length
  always_comb begin
    count_inc = count_q + 1'b1;
    if (count_inc == cycle_len_q) begin
      count_inc = '0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    paused_d     = paused_q;
    is_spp_d     = is_spp_q;
    prod_d       = prod_q;
    beat_d       = beat_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = cycle_len_q;
    unique case (state_q)
      mcbt_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            mcbt_pkg::CMD_CLOCK: begin
              if (!paused_q) begin
                if (cpb_q == '0) begin
                  count_d = count_inc;
                end else begin
                  div_start    = 1'b1;
                  div_dividend = mcbt_pkg::PROD_W'(count_q);
                  div_divisor  = {1'b0, cpb_q};
                  is_spp_d     = 1'b0;
                  state_d      = mcbt_pkg::ST_DIV;
                end
              end
            end
            mcbt_pkg::CMD_START: begin
              count_d  = '0;
              paused_d = 1'b0;
            end
            mcbt_pkg::CMD_STOP:     paused_d = 1'b1;
            mcbt_pkg::CMD_CONTINUE: paused_d = 1'b0;
            mcbt_pkg::CMD_SPP: begin
              // position * 6 = position * 4 + position * 2
              prod_d   = {1'b0, cmd_i.pos, 2'b00} + {2'b00, cmd_i.pos, 1'b0};
              is_spp_d = 1'b1;
              state_d  = mcbt_pkg::ST_MUL;
            end
            default: state_d = mcbt_pkg::ST_IDLE;
          endcase
        end
      end
      mcbt_pkg::ST_MUL: begin
        div_start = 1'b1;
        state_d   = mcbt_pkg::ST_DIV;
      end
      mcbt_pkg::ST_DIV: begin
        if (div_done) begin
          if (is_spp_q) begin
            count_d = div_rem;
            state_d = mcbt_pkg::ST_IDLE;
          end else if (div_rem == '0) begin
            state_d = mcbt_pkg::ST_EMIT;
          end else begin
            count_d = count_inc;
            state_d = mcbt_pkg::ST_IDLE;
          end
        end
      end
      mcbt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          beat_d      = div_quo;
          count_d     = count_inc;
          state_d     = mcbt_pkg::ST_IDLE;
        end
      end
      default: state_d = mcbt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcbt_pkg::ST_IDLE;
      count_q     <= '0;
      paused_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cpb_q       <= mcbt_pkg::CLOCKS_PER_BEAT_RST;
      cycle_len_q <= mcbt_pkg::CYCLE_LENGTH_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      paused_q    <= paused_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mcbt_pkg::REG_CLOCKS_PER_BEAT: cpb_q       <= cfg_data_i[mcbt_pkg::CPB_W-1:0];
          mcbt_pkg::REG_CYCLE_LENGTH:    cycle_len_q <= cfg_data_i;
          default:                       cpb_q       <= cpb_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    is_spp_q <= is_spp_d;
    prod_q   <= prod_d;
    beat_q   <= beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = beat_q;

  `ASSERT_IMPLY(a_done_only_in_div, div_done, state_q == mcbt_pkg::ST_DIV)
  `ASSERT_IMPLY(a_pop_only_idle, pop_o, state_q == mcbt_pkg::ST_IDLE)
  `ASSERT_NEXT(a_emit_shows_beat, state_q == mcbt_pkg::ST_EMIT && out_free, out_valid_q)

endmodule

/* src/midi_clock_beat_tracker_core.sv */
// Top level of the MIDI clock beat tracker.
//
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+-------------------------------
// s_axis   | in  | tvalid / tready        | tdata[7:0] = rx_byte
// m_axis   | out | tvalid / tready        | tdata[7:0] = beat_index
// cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i[7:0]
//
// Start, Stop, Continue and a paused clock byte stay in the idle state; other
// ignored bytes never enter the queue. A running clock byte (nonzero clocks
// per beat) uses the shared divider, as SPP does after a multiply, and emits
// a beat on a zero remainder. The divider makes one quotient bit per cycle
// over 17 steps. The input queue (QueueDepth commands) takes bytes while the
// back end works or a beat waits on m_axis. Reset is asynchronous, active
// low, and needs no clearing pass. Config writes are always accepted.
module midi_clock_beat_tracker_core #(
  parameter int unsigned QueueDepth = mcbt_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] beat_index
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic           full, empty, push, pop;
  mcbt_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  mcbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid),
    .rx_byte_i  (s_axis_tdata),
    .rx_ready_o (s_axis_tready),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mcbt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  mcbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (m_axis_tdata)
  );

endmodule
